### hw/rtl/gcb_pkg.sv
// Shared types and constants for the grapheme cluster boundary unit.
// Holds the break class codes, the queue item layout and the class range table.
// No dependencies.
`timescale 1ns / 1ps

package gcb_pkg;

  // Grapheme break classes; CLS_NONE marks "no previous code point".
  typedef enum logic [3:0] {
    CLS_OTHER   = 4'd0,
    CLS_CR      = 4'd1,
    CLS_LF      = 4'd2,
    CLS_CONTROL = 4'd3,
    CLS_EXTEND  = 4'd4,
    CLS_ZWJ     = 4'd5,
    CLS_RI      = 4'd6,
    CLS_PREPEND = 4'd7,
    CLS_SPACING = 4'd8,
    CLS_L       = 4'd9,
    CLS_V       = 4'd10,
    CLS_T       = 4'd11,
    CLS_LV      = 4'd12,
    CLS_LVT     = 4'd13,
    CLS_PICT    = 4'd14,
    CLS_NONE    = 4'd15
  } cls_t;

  localparam int CP_W = 21;

  // Classified item passed from front to back.
  typedef struct packed {
    cls_t cls;
    logic first;
  } item_t;

  // Hangul syllable block.
  localparam logic [CP_W-1:0] HANGUL_LO = 21'h0AC00;
  localparam logic [CP_W-1:0] HANGUL_HI = 21'h0D7A3;
  localparam int HANGUL_OFF_W = 14;  // offsets up to 11171
  localparam int HANGUL_T_CNT = 28;  // trailing consonant count (plus none)
  // Reciprocal of 28 scaled by 2^20, rounded up; exact over the offset range.
  localparam int RECIP_SHIFT = 20;
  localparam logic [15:0] RECIP_28 = 16'd37450;
  localparam int QUO_W = 9;          // quotient max 398

  localparam logic [CP_W-1:0] CP_CR    = 21'h0000D;
  localparam logic [CP_W-1:0] CP_LF    = 21'h0000A;
  localparam logic [CP_W-1:0] CP_ZWJ   = 21'h0200D;
  localparam logic [CP_W-1:0] CP_RI_LO = 21'h1F1E6;
  localparam logic [CP_W-1:0] CP_RI_HI = 21'h1F1FF;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    cls_t            cls;
  } span_t;

  localparam int NUM_SPANS = 49;

  // Scanned in order; the first matching span wins.
  localparam span_t SPANS [NUM_SPANS] = '{
    '{21'h00300, 21'h0036F, CLS_EXTEND}, '{21'h01AB0, 21'h01AFF, CLS_EXTEND},
    '{21'h01DC0, 21'h01DFF, CLS_EXTEND}, '{21'h0FE20, 21'h0FE2F, CLS_EXTEND},
    '{21'h0FE00, 21'h0FE0F, CLS_EXTEND}, '{21'hE0100, 21'hE01EF, CLS_EXTEND},
    '{21'h020D0, 21'h020FF, CLS_EXTEND}, '{21'h0064B, 21'h0065F, CLS_EXTEND},
    '{21'h00610, 21'h0061A, CLS_EXTEND}, '{21'h00591, 21'h005BD, CLS_EXTEND},
    '{21'h005BF, 21'h005BF, CLS_EXTEND}, '{21'h005C1, 21'h005C2, CLS_EXTEND},
    '{21'h005C4, 21'h005C5, CLS_EXTEND}, '{21'h005C7, 21'h005C7, CLS_EXTEND},
    '{21'h00900, 21'h00903, CLS_EXTEND}, '{21'h0093A, 21'h0094F, CLS_EXTEND},
    '{21'h1F3FB, 21'h1F3FF, CLS_EXTEND}, '{21'h0200C, 21'h0200C, CLS_EXTEND},
    '{21'h0200E, 21'h0200F, CLS_EXTEND},
    '{21'h00E31, 21'h00E3A, CLS_SPACING}, '{21'h00EB1, 21'h00EBC, CLS_SPACING},
    '{21'h1F300, 21'h1F64F, CLS_PICT}, '{21'h1F680, 21'h1F6FF, CLS_PICT},
    '{21'h1F900, 21'h1FAFF, CLS_PICT}, '{21'h02600, 21'h027BF, CLS_PICT},
    '{21'h000A9, 21'h000A9, CLS_PICT}, '{21'h000AE, 21'h000AE, CLS_PICT},
    '{21'h0203C, 21'h0203C, CLS_PICT}, '{21'h02049, 21'h02049, CLS_PICT},
    '{21'h02122, 21'h02139, CLS_PICT}, '{21'h02194, 21'h021AA, CLS_PICT},
    '{21'h0231A, 21'h0231B, CLS_PICT}, '{21'h02328, 21'h02328, CLS_PICT},
    '{21'h023CF, 21'h023CF, CLS_PICT}, '{21'h023E9, 21'h023F3, CLS_PICT},
    '{21'h023F8, 21'h023FA, CLS_PICT}, '{21'h025AA, 21'h025AB, CLS_PICT},
    '{21'h025B6, 21'h025B6, CLS_PICT}, '{21'h025C0, 21'h025C0, CLS_PICT},
    '{21'h025FB, 21'h025FE, CLS_PICT}, '{21'h02934, 21'h02935, CLS_PICT},
    '{21'h02B05, 21'h02B07, CLS_PICT}, '{21'h02B1B, 21'h02B1C, CLS_PICT},
    '{21'h02B50, 21'h02B50, CLS_PICT}, '{21'h02B55, 21'h02B55, CLS_PICT},
    '{21'h03030, 21'h03030, CLS_PICT}, '{21'h0303D, 21'h0303D, CLS_PICT},
    '{21'h03297, 21'h03297, CLS_PICT}, '{21'h03299, 21'h03299, CLS_PICT}
  };

endpackage

### hw/rtl/gcb_front.sv
// Front end: accepts code points and sorts them into break classes.
// One register stage holds the range class and the Hangul quotient.
// Depends on gcb_pkg.
`timescale 1ns / 1ps

module gcb_front
  import gcb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CP_W-1:0] code_point,
  input  logic            first_of_text,
  output logic            out_valid,
  input  logic            out_ready,
  output item_t           out_item
);

  cls_t                    base_cls;
  logic                    hangul_hit;
  logic [HANGUL_OFF_W-1:0] hangul_off;
  logic [29:0]             product;

  // Stage registers
  logic                    vld;
  cls_t                    cls_reg;
  logic                    hangul_reg;
  logic                    first_reg;
  logic [HANGUL_OFF_W-1:0] off_reg;
  logic [QUO_W-1:0]        quo_reg;

  logic [HANGUL_OFF_W-1:0] quo_times;

  always_comb begin
    base_cls   = CLS_OTHER;
    hangul_hit = 1'b0;
    if (code_point == CP_CR) begin
      base_cls = CLS_CR;
    end else if (code_point == CP_LF) begin
      base_cls = CLS_LF;
    end else if (code_point < 21'h00020 ||
                 (code_point >= 21'h0007F && code_point <= 21'h0009F)) begin
      base_cls = CLS_CONTROL;
    end else if (code_point == CP_ZWJ) begin
      base_cls = CLS_ZWJ;
    end else if (code_point >= CP_RI_LO && code_point <= CP_RI_HI) begin
      base_cls = CLS_RI;
    end else if ((code_point >= 21'h01100 && code_point <= 21'h0115F) ||
                 (code_point >= 21'h0A960 && code_point <= 21'h0A97C)) begin
      base_cls = CLS_L;
    end else if ((code_point >= 21'h01160 && code_point <= 21'h011A7) ||
                 (code_point >= 21'h0D7B0 && code_point <= 21'h0D7C6)) begin
      base_cls = CLS_V;
    end else if ((code_point >= 21'h011A8 && code_point <= 21'h011FF) ||
                 (code_point >= 21'h0D7CB && code_point <= 21'h0D7FB)) begin
      base_cls = CLS_T;
    end else if (code_point >= HANGUL_LO && code_point <= HANGUL_HI) begin
      base_cls   = CLS_LVT;
      hangul_hit = 1'b1;
    end else begin
      // Walk backward so the earliest matching span sets the class last.
      for (int i = NUM_SPANS - 1; i >= 0; i--) begin
        if (code_point >= SPANS[i].lo && code_point <= SPANS[i].hi) begin
          base_cls = SPANS[i].cls;
        end
      end
    end
  end

  // Offset into the syllable block; only meaningful on a Hangul hit.
  assign hangul_off = HANGUL_OFF_W'(code_point - HANGUL_LO);
  assign product    = {16'd0, hangul_off} * {14'd0, RECIP_28};

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cls_reg    <= base_cls;
      hangul_reg <= hangul_hit;
      first_reg  <= first_of_text;
      off_reg    <= hangul_off;
      quo_reg    <= product[RECIP_SHIFT +: QUO_W];
    end
  end

  // quotient * 28 by shift and subtract; a match means no trailing consonant
  assign quo_times = HANGUL_OFF_W'({quo_reg, 5'd0}) - HANGUL_OFF_W'({quo_reg, 2'd0});

  assign out_valid      = vld;
  assign out_item.first = first_reg;
  always_comb begin
    out_item.cls = cls_reg;
    if (hangul_reg) begin
      out_item.cls = (quo_times == off_reg) ? CLS_LV : CLS_LVT;
    end
  end

endmodule

### hw/rtl/gcb_queue.sv
// Short queue of classified items between the front end and the rule engine.
// Register-based, one write and one read per cycle; writes are refused while the queue is full.
// Depends on gcb_pkg.
`timescale 1ns / 1ps

module gcb_queue
  import gcb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

### hw/rtl/gcb_rules.sv
// Back end: applies the boundary rules against the previous class and
// the regional indicator parity, and drives the output register.
// Depends on gcb_pkg.
`timescale 1ns / 1ps

module gcb_rules
  import gcb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_break,
  output cls_t  out_cls
);

  cls_t prev_cls;
  logic regional_odd;
  logic brk;
  logic rule_brk;
  logic odd_next;
  logic take;
  cls_t p;
  cls_t c;

  assign p = prev_cls;
  assign c = in_item.cls;

  function automatic logic is_ctl(cls_t k);
    return (k == CLS_CONTROL) || (k == CLS_CR) || (k == CLS_LF);
  endfunction

  always_comb begin
    if (p == CLS_CR && c == CLS_LF) begin
      rule_brk = 1'b0;
    end else if (is_ctl(p) || is_ctl(c)) begin
      rule_brk = 1'b1;
    end else if (p == CLS_L &&
                 (c == CLS_L || c == CLS_V || c == CLS_LV || c == CLS_LVT)) begin
      rule_brk = 1'b0;
    end else if ((p == CLS_LV || p == CLS_V) && (c == CLS_V || c == CLS_T)) begin
      rule_brk = 1'b0;
    end else if ((p == CLS_LVT || p == CLS_T) && c == CLS_T) begin
      rule_brk = 1'b0;
    end else if (c == CLS_EXTEND || c == CLS_ZWJ || c == CLS_SPACING) begin
      rule_brk = 1'b0;
    end else if (p == CLS_PREPEND) begin
      rule_brk = 1'b0;
    end else if (p == CLS_ZWJ && c == CLS_PICT) begin
      rule_brk = 1'b0;
    end else if (p == CLS_RI && c == CLS_RI) begin
      rule_brk = !regional_odd;
    end else begin
      rule_brk = 1'b1;
    end
  end

  assign brk = in_item.first || (p == CLS_NONE) || rule_brk;

  always_comb begin
    if (brk) begin
      odd_next = (c == CLS_RI);
    end else if (c == CLS_RI) begin
      odd_next = !regional_odd;
    end else if (p != CLS_RI) begin
      odd_next = 1'b0;
    end else begin
      odd_next = regional_odd;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cls     <= CLS_NONE;
      regional_odd <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        prev_cls     <= c;
        regional_odd <= odd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_break <= brk;
      out_cls   <= c;
    end
  end

endmodule

### hw/rtl/grapheme_cluster_boundary_unit.sv
// Top level of the grapheme cluster boundary unit (simplified UAX #29).
// Ties front end, item queue and rule engine together.
// Depends on gcb_pkg, gcb_front, gcb_queue, gcb_rules.
//
//   channel   direction  tdata                 tuser
//   s_*       in         [20:0] code_point     [0] first_of_text
//   m_*       out        [3:0]  break_class    [0] break_before
//
// One code point per cycle sustained while m_tready stays high; each item passes
// the front register, the queue and the output register in that order. The rate
// is set by the rule engine, which updates the previous class and regional
// parity once per item.
// Reset (rst, synchronous) empties all stages and clears the state to "no
// previous code point". A stall on the output fills the queue first; the input
// side keeps taking transfers until the queue and front register are full.
`timescale 1ns / 1ps

module grapheme_cluster_boundary_unit
  import gcb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
  input  logic [0:0]  s_tuser,   // [0] first_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] break_class, [7:4] zero
  output logic [0:0]  m_tuser    // [0] break_before
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  logic  brk;
  cls_t  cls;

  // Classify incoming code points.
  gcb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .code_point    (s_tdata[CP_W-1:0]),
    .first_of_text (s_tuser[0]),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_item      (f_item)
  );

  // Decouple classification from the rule engine.
  gcb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Decide the boundary and hold the result until the transfer completes.
  gcb_rules u_rules (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_break (brk),
    .out_cls   (cls)
  );

  assign m_tdata = {4'd0, cls};
  assign m_tuser = brk;

endmodule

### tb/sv/grapheme_cluster_boundary_unit_tb.sv
// Self-checking testbench for grapheme_cluster_boundary_unit.
// Drives code points on the input stream, predicts class and break flag, checks each result.
// Depends on gcb_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module grapheme_cluster_boundary_unit_tb;
  import gcb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_MSGS    = 60;

  // Shapes of text that the random generator strings together.
  typedef enum int {
    TXT_PLAIN, TXT_HANGUL, TXT_EMOJI, TXT_FLAGS, TXT_NEWLINE, TXT_NOISE
  } text_shape_t;

  typedef struct packed {
    logic [20:0] lo;
    logic [20:0] hi;
    cls_t        cls;
  } cp_span_t;

  typedef struct packed {
    logic brk;
    cls_t cls;
  } boundary_t;

  // Marks and pictographs by range; the first span that holds a code point wins.
  localparam int N_SPANS = 49;
  localparam cp_span_t MARK_SPANS [N_SPANS] = '{
    '{21'h00300, 21'h0036F, CLS_EXTEND}, '{21'h01AB0, 21'h01AFF, CLS_EXTEND},
    '{21'h01DC0, 21'h01DFF, CLS_EXTEND}, '{21'h0FE20, 21'h0FE2F, CLS_EXTEND},
    '{21'h0FE00, 21'h0FE0F, CLS_EXTEND}, '{21'hE0100, 21'hE01EF, CLS_EXTEND},
    '{21'h020D0, 21'h020FF, CLS_EXTEND}, '{21'h0064B, 21'h0065F, CLS_EXTEND},
    '{21'h00610, 21'h0061A, CLS_EXTEND}, '{21'h00591, 21'h005BD, CLS_EXTEND},
    '{21'h005BF, 21'h005BF, CLS_EXTEND}, '{21'h005C1, 21'h005C2, CLS_EXTEND},
    '{21'h005C4, 21'h005C5, CLS_EXTEND}, '{21'h005C7, 21'h005C7, CLS_EXTEND},
    '{21'h00900, 21'h00903, CLS_EXTEND}, '{21'h0093A, 21'h0094F, CLS_EXTEND},
    '{21'h1F3FB, 21'h1F3FF, CLS_EXTEND}, '{21'h0200C, 21'h0200C, CLS_EXTEND},
    '{21'h0200E, 21'h0200F, CLS_EXTEND},
    '{21'h00E31, 21'h00E3A, CLS_SPACING}, '{21'h00EB1, 21'h00EBC, CLS_SPACING},
    '{21'h1F300, 21'h1F64F, CLS_PICT}, '{21'h1F680, 21'h1F6FF, CLS_PICT},
    '{21'h1F900, 21'h1FAFF, CLS_PICT}, '{21'h02600, 21'h027BF, CLS_PICT},
    '{21'h000A9, 21'h000A9, CLS_PICT}, '{21'h000AE, 21'h000AE, CLS_PICT},
    '{21'h0203C, 21'h0203C, CLS_PICT}, '{21'h02049, 21'h02049, CLS_PICT},
    '{21'h02122, 21'h02139, CLS_PICT}, '{21'h02194, 21'h021AA, CLS_PICT},
    '{21'h0231A, 21'h0231B, CLS_PICT}, '{21'h02328, 21'h02328, CLS_PICT},
    '{21'h023CF, 21'h023CF, CLS_PICT}, '{21'h023E9, 21'h023F3, CLS_PICT},
    '{21'h023F8, 21'h023FA, CLS_PICT}, '{21'h025AA, 21'h025AB, CLS_PICT},
    '{21'h025B6, 21'h025B6, CLS_PICT}, '{21'h025C0, 21'h025C0, CLS_PICT},
    '{21'h025FB, 21'h025FE, CLS_PICT}, '{21'h02934, 21'h02935, CLS_PICT},
    '{21'h02B05, 21'h02B07, CLS_PICT}, '{21'h02B1B, 21'h02B1C, CLS_PICT},
    '{21'h02B50, 21'h02B50, CLS_PICT}, '{21'h02B55, 21'h02B55, CLS_PICT},
    '{21'h03030, 21'h03030, CLS_PICT}, '{21'h0303D, 21'h0303D, CLS_PICT},
    '{21'h03297, 21'h03297, CLS_PICT}, '{21'h03299, 21'h03299, CLS_PICT}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [20:0] code_point, [23:21] zero
  logic [0:0]  s_tuser  = '0;   // [0] first_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [3:0] break_class, [7:4] zero
  logic [0:0]  m_tuser;         // [0] break_before

  // Predictor state: class of the last code point and regional indicator parity.
  cls_t      prev_cls = CLS_NONE;
  bit        ri_odd   = 1'b0;
  boundary_t boundary_q[$];

  int items_sent   = 0;
  int results_seen = 0;
  int err_count    = 0;
  int cycle_count  = 0;
  int hold_cycles  = 0;     // long receiver hold-off, picked up by the receiver
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;

  grapheme_cluster_boundary_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic bit in_range(logic [20:0] cp, logic [20:0] lo, logic [20:0] hi);
    return cp >= lo && cp <= hi;
  endfunction

  function automatic cls_t classify_cp(logic [20:0] cp);
    cls_t k;
    int   i;
    k = CLS_OTHER;
    if (cp == CP_CR) k = CLS_CR;
    else if (cp == CP_LF) k = CLS_LF;
    else if (cp < 21'h20 || in_range(cp, 21'h7F, 21'h9F)) k = CLS_CONTROL;
    else if (cp == CP_ZWJ) k = CLS_ZWJ;
    else if (in_range(cp, CP_RI_LO, CP_RI_HI)) k = CLS_RI;
    else if (in_range(cp, 21'h1100, 21'h115F) || in_range(cp, 21'hA960, 21'hA97C)) k = CLS_L;
    else if (in_range(cp, 21'h1160, 21'h11A7) || in_range(cp, 21'hD7B0, 21'hD7C6)) k = CLS_V;
    else if (in_range(cp, 21'h11A8, 21'h11FF) || in_range(cp, 21'hD7CB, 21'hD7FB)) k = CLS_T;
    else if (in_range(cp, 21'hAC00, 21'hD7A3)) begin
      // syllables with no trailing consonant sit on multiples of 28 from the base
      k = ((cp - 21'hAC00) % 28 == 0) ? CLS_LV : CLS_LVT;
    end else begin
      // scan backward so the earliest matching span is the one left standing
      for (i = N_SPANS - 1; i >= 0; i--) begin
        if (in_range(cp, MARK_SPANS[i].lo, MARK_SPANS[i].hi)) k = MARK_SPANS[i].cls;
      end
    end
    return k;
  endfunction

  function automatic bit is_ctl(cls_t c);
    return c == CLS_CONTROL || c == CLS_CR || c == CLS_LF;
  endfunction

  function automatic bit is_break(cls_t p, cls_t c, bit odd);
    if (p == CLS_CR && c == CLS_LF) return 1'b0;
    if (is_ctl(p) || is_ctl(c)) return 1'b1;
    if (p == CLS_L && (c == CLS_L || c == CLS_V || c == CLS_LV || c == CLS_LVT)) return 1'b0;
    if ((p == CLS_LV || p == CLS_V) && (c == CLS_V || c == CLS_T)) return 1'b0;
    if ((p == CLS_LVT || p == CLS_T) && c == CLS_T) return 1'b0;
    if (c == CLS_EXTEND || c == CLS_ZWJ || c == CLS_SPACING) return 1'b0;
    if (p == CLS_PREPEND) return 1'b0;
    if (p == CLS_ZWJ && c == CLS_PICT) return 1'b0;
    // an odd count so far means this indicator closes a pair
    if (p == CLS_RI && c == CLS_RI) return !odd;
    return 1'b1;
  endfunction

  function automatic void predict_boundary(logic [20:0] cp, bit first);
    cls_t      c;
    boundary_t e;
    c = classify_cp(cp);
    e.cls = c;
    e.brk = first || prev_cls == CLS_NONE || is_break(prev_cls, c, ri_odd);
    if (e.brk) ri_odd = (c == CLS_RI);
    else if (c == CLS_RI) ri_odd = !ri_odd;
    else if (prev_cls != CLS_RI) ri_odd = 1'b0;
    prev_cls = c;
    boundary_q.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [20:0] pick_cp(cls_t k);
    logic [20:0] cp;
    int          v;
    v = $urandom_range(0, 3);
    case (k)
      CLS_CR: cp = CP_CR;
      CLS_LF: cp = CP_LF;
      CLS_CONTROL: begin
        if (v[0]) cp = 21'($urandom_range(21'h7F, 21'h9F));
        else cp = 21'($urandom_range(0, 21'h1F));
        if (cp == CP_CR || cp == CP_LF) cp = 21'h0;
      end
      CLS_EXTEND: begin
        case (v)
          0: cp = 21'($urandom_range(21'h300, 21'h36F));
          1: cp = 21'($urandom_range(21'h1F3FB, 21'h1F3FF));
          2: cp = 21'($urandom_range(21'hE0100, 21'hE01EF));
          default: cp = 21'($urandom_range(21'hFE00, 21'hFE0F));
        endcase
      end
      CLS_ZWJ: cp = CP_ZWJ;
      CLS_RI: cp = 21'($urandom_range(CP_RI_LO, CP_RI_HI));
      CLS_SPACING: begin
        if (v[0]) cp = 21'($urandom_range(21'hE31, 21'hE3A));
        else cp = 21'($urandom_range(21'hEB1, 21'hEBC));
      end
      CLS_L: begin
        if (v[0]) cp = 21'($urandom_range(21'h1100, 21'h115F));
        else cp = 21'($urandom_range(21'hA960, 21'hA97C));
      end
      CLS_V: begin
        if (v[0]) cp = 21'($urandom_range(21'h1160, 21'h11A7));
        else cp = 21'($urandom_range(21'hD7B0, 21'hD7C6));
      end
      CLS_T: begin
        if (v[0]) cp = 21'($urandom_range(21'h11A8, 21'h11FF));
        else cp = 21'($urandom_range(21'hD7CB, 21'hD7FB));
      end
      CLS_LV: cp = 21'(21'hAC00 + 28 * $urandom_range(0, 398));
      CLS_LVT: cp = 21'(21'hAC00 + 28 * $urandom_range(0, 398) + $urandom_range(1, 27));
      CLS_PICT: begin
        case (v)
          0: cp = 21'($urandom_range(21'h1F300, 21'h1F3FA));
          1: cp = 21'($urandom_range(21'h1F680, 21'h1F6FF));
          2: cp = 21'($urandom_range(21'h2600, 21'h27BF));
          default: cp = 21'hA9;
        endcase
      end
      default: begin
        // plain letters, CJK, surrogates and values past the last scalar
        case (v)
          0: cp = 21'($urandom_range(21'h20, 21'h7E));
          1: cp = 21'($urandom_range(21'h4E00, 21'h9FFF));
          2: cp = 21'($urandom_range(21'hD800, 21'hDFFF));
          default: cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
        endcase
      end
    endcase
    return cp;
  endfunction

  function automatic cls_t pick_mark_cls();
    int v;
    v = $urandom_range(0, 3);
    if (v == 0) return CLS_SPACING;
    if (v == 1) return CLS_ZWJ;
    return CLS_EXTEND;
  endfunction

  // Offer one code point and hold it until the transfer; called right at a clock edge.
  task automatic send_code_point(logic [20:0] cp, bit first);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, cp};
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    predict_boundary(cp, first);
    items_sent++;
  endtask

  // Send one cluster-shaped run; only the lead item may carry first_of_text, except in noise runs.
  task automatic send_cluster(text_shape_t shape);
    bit lead;
    int v;
    lead = ($urandom_range(0, 39) == 0);
    v = $urandom_range(0, 3);
    case (shape)
      TXT_PLAIN: begin
        if (v == 0) send_code_point(pick_cp(CLS_PICT), lead);
        else if (v == 1) send_code_point(pick_cp(CLS_LV), lead);
        else send_code_point(pick_cp(CLS_OTHER), lead);
        repeat ($urandom_range(0, 3)) send_code_point(pick_cp(pick_mark_cls()), 1'b0);
      end
      TXT_HANGUL: begin
        if (v < 2) begin
          send_code_point(pick_cp(CLS_L), lead);
          repeat ($urandom_range(0, 2)) send_code_point(pick_cp(CLS_L), 1'b0);
          if (v == 0) begin
            repeat ($urandom_range(1, 2)) send_code_point(pick_cp(CLS_V), 1'b0);
          end else begin
            send_code_point(pick_cp($urandom_range(0, 1) ? CLS_LV : CLS_LVT), 1'b0);
          end
        end else if (v == 2) begin
          send_code_point(pick_cp(CLS_LV), lead);
          repeat ($urandom_range(0, 2)) send_code_point(pick_cp(CLS_V), 1'b0);
        end else begin
          send_code_point(pick_cp(CLS_LVT), lead);
        end
        repeat ($urandom_range(0, 2)) send_code_point(pick_cp(CLS_T), 1'b0);
        if ($urandom_range(0, 3) == 0) send_code_point(pick_cp(CLS_EXTEND), 1'b0);
      end
      TXT_EMOJI: begin
        send_code_point(pick_cp(CLS_PICT), lead);
        if (v[0]) send_code_point(pick_cp(CLS_EXTEND), 1'b0);
        repeat ($urandom_range(0, 3)) begin
          send_code_point(CP_ZWJ, 1'b0);
          send_code_point(pick_cp($urandom_range(0, 4) ? CLS_PICT : CLS_OTHER), 1'b0);
        end
      end
      TXT_FLAGS: begin
        send_code_point(pick_cp(CLS_RI), lead);
        repeat ($urandom_range(0, 4)) send_code_point(pick_cp(CLS_RI), 1'b0);
      end
      TXT_NEWLINE: begin
        if (v == 0) begin
          send_code_point(CP_CR, lead);
          send_code_point(CP_LF, 1'b0);
        end else if (v == 1) send_code_point(CP_CR, lead);
        else if (v == 2) send_code_point(CP_LF, lead);
        else send_code_point(pick_cp(CLS_CONTROL), lead);
      end
      default: begin
        // broken runs: any class, raw 21-bit values, stray first flags
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1)) begin
            send_code_point(21'($urandom_range(0, 21'h1FFFFF)), $urandom_range(0, 3) == 0);
          end else begin
            send_code_point(pick_cp(cls_t'($urandom_range(0, 14))), $urandom_range(0, 3) == 0);
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    send_code_point(21'h00061, 1'b0);   // very first item: no previous class, must break
    send_code_point(21'h00000, 1'b0);   // lowest code point, control
    send_code_point(CP_CR, 1'b0);
    send_code_point(CP_LF, 1'b0);       // CR LF stays together
    send_code_point(CP_CR, 1'b0);
    send_code_point(21'h00062, 1'b0);   // break after a lone CR
    send_code_point(21'h00300, 1'b0);   // extend attaches
    send_code_point(CP_ZWJ, 1'b0);
    send_code_point(21'h1F600, 1'b0);   // emoji joined after ZWJ
    send_code_point(21'h1F3FB, 1'b0);   // skin tone modifier is extend, not pictographic
    send_code_point(21'h00301, 1'b1);   // first of text overrides the extend rule
    send_code_point(21'h01100, 1'b0);   // L V T
    send_code_point(21'h01160, 1'b0);
    send_code_point(21'h011A8, 1'b0);
    send_code_point(21'h0AC00, 1'b0);   // lowest syllable, LV
    send_code_point(21'h011A8, 1'b0);
    send_code_point(21'h0D7A3, 1'b0);   // highest syllable, LVT
    send_code_point(CP_RI_LO, 1'b0);    // indicators pair up, third one breaks
    send_code_point(CP_RI_HI, 1'b0);
    send_code_point(CP_RI_LO, 1'b0);
    send_code_point(21'h00E31, 1'b0);   // spacing mark
    send_code_point(21'h1FFFFF, 1'b0);  // all ones, beyond the scalar range
    send_code_point(21'h10FFFF, 1'b0);
    send_code_point(21'h0DFFF, 1'b0);   // surrogate
    send_code_point(21'h0009F, 1'b1);
  endtask

  task automatic test_hangul_runs();
    repeat (40) send_cluster(TXT_HANGUL);
  endtask

  task automatic test_emoji_and_flags();
    repeat (50) send_cluster($urandom_range(0, 1) ? TXT_EMOJI : TXT_FLAGS);
  endtask

  // Hold the output off for a long stretch while input keeps coming, so the
  // queue fills and the input side stalls.
  task automatic test_output_stall();
    tx_idle = 1'b0;
    hold_cycles = 300;
    repeat (20) send_cluster(TXT_PLAIN);
    tx_idle = 1'b1;
  endtask

  task automatic test_random_text(int target);
    int seg;
    int v;
    seg = 0;
    while (items_sent < target) begin
      if (seg == 0) begin
        // switch idling per stretch so some stretches run flat out
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        seg = $urandom_range(20, 60);
      end
      seg--;
      v = $urandom_range(0, 15);
      if (v < 5) send_cluster(TXT_PLAIN);
      else if (v < 8) send_cluster(TXT_HANGUL);
      else if (v < 10) send_cluster(TXT_EMOJI);
      else if (v < 12) send_cluster(TXT_FLAGS);
      else if (v < 14) send_cluster(TXT_NEWLINE);
      else send_cluster(TXT_NOISE);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= MAX_MSGS) begin
      $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    boundary_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (boundary_q.size() == 0) begin
        report_mismatch("result with nothing pending, class", m_tdata, 0);
      end else begin
        want = boundary_q.pop_front();
        if (m_tuser[0] !== want.brk) report_mismatch("break_before", m_tuser[0], want.brk);
        if (m_tdata !== {4'b0000, want.cls}) report_mismatch("break_class", m_tdata, want.cls);
      end
      results_seen++;
    end
  end

  // Receiver: random stall per result, plus the long hold-off on request.
  initial begin : receiver
    int stall;
    int held;
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        for (held = 0; held < hold_cycles; held++) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 19) : 0;
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[grapheme_cluster_boundary_unit] ERROR");
    $finish;
  end

  initial begin : main
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_hangul_runs();
    test_emoji_and_flags();
    test_output_stall();
    test_random_text(1950);
    s_tvalid <= 1'b0;
    // drain, then give the pipeline time to show any stray result
    while (boundary_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[grapheme_cluster_boundary_unit] OK");
    end else begin
      $display("[grapheme_cluster_boundary_unit] ERROR");
    end
    $finish;
  end

endmodule
